### src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants and types for the allocator and its checker.
// ----------------------------------------------------------------------------
`default_nettype none
package ffha_pkg;
  localparam int HEAP_BYTES_DEF   = 1048576;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int MAX_BLOCKS_DEF   = 256;
  localparam int ADDR_W           = 20;
  localparam int REQ_W            = 21;
  localparam int ALIGN_BYTES      = 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_ZERO   = 2'd2,
    ST_BAD    = 2'd3
  } status_t;
endpackage
`default_nettype wire

### src/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Block table in one memory, walked by a sequencer sharing one read port.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries a request: tdata = {address, request_bytes, opcode}
//   (opcode at bit 0). m_axis returns one reply per request: tdata =
//   {status, payload_address}. s_axis_tready is high only while the
//   sequencer is idle; one request is worked on at a time.
//   A scan step reads one table entry. An allocate scans until the first
//   fit, then for a split shifts the tail up one entry at a time and writes
//   the two halves; a free scans for the address, then compacts the whole
//   table one entry at a time. The reply for a zero-size or null request
//   needs no table scan. The next request is taken from the cycle the reply
//   is valid; the single memory read port makes every walk go entry by entry.
//   Reset leaves one free block covering the heap less one header; no
//   clearing pass is needed. A stalled reply waits in the output register;
//   a finished request behind it holds the sequencer and s_axis_tready low.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_heap_allocator_unit #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[0], request_bytes[21:1], address[41:22], zero pad[47:42]
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // payload_address[19:0], status[21:20], zero pad[23:22]
  output logic [23:0]      m_axis_tdata
);
  import ffha_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = IW + 1;
  localparam int SW = $clog2(HEAP_BYTES) + 1;
  localparam int NW = (SW > REQ_W + 1) ? SW : REQ_W + 1;
  localparam int PW = (SW > ADDR_W) ? SW : ADDR_W;
  localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);
  localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD    = 10'b0000000010,
    S_CHK   = 10'b0000000100,
    S_SHRD  = 10'b0000001000,
    S_SHWR  = 10'b0000010000,
    S_SPLIT = 10'b0000100000,
    S_MRD   = 10'b0001000000,
    S_MCHK  = 10'b0010000000,
    S_MEND  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic [SW-1:0] start;
    logic [SW-1:0] size;
    logic          free;
  } entry_t;

  entry_t mem [MAX_BLOCKS];
  entry_t rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  state_t state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] widx;
  logic          op;
  logic [NW-1:0] need;
  logic [ADDR_W-1:0] addr;
  entry_t        hit;
  entry_t        acc;
  logic [SW-1:0] ins_start;
  logic [SW-1:0] ins_size;
  logic          do_split;
  logic [ADDR_W-1:0] res_addr;
  status_t       res_status;
  logic [CW-1:0] hit_idx;

  logic              out_valid;
  logic [ADDR_W-1:0] out_addr;
  status_t           out_status;
  logic              out_free;

  logic [REQ_W-1:0] req_in;
  logic [NW-1:0]    need_w;
  logic             fits;
  logic             big;
  logic             split_ok;
  entry_t           m_ent;
  logic             merge_hit;

  // entry 0 follows reset until first written
  logic e0_written;
  entry_t e0_reset;
  entry_t mem_q;
  logic   rd_zero;

  assign e0_reset = '{start: '0, size: SW'(HEAP_BYTES - HEADER_BYTES), free: 1'b1};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
    rd_zero <= (rd_addr == '0);
  end

  assign rd_data = (rd_zero && !e0_written) ? e0_reset : mem_q;

  assign req_in = s_axis_tdata[21:1];
  assign need_w = (NW'(req_in) + NW'(ALIGN_BYTES - 1)) & ~NW'(ALIGN_BYTES - 1);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_status, out_addr};
  assign out_free      = !out_valid || m_axis_tready;

  assign fits = rd_data.free && (NW'(rd_data.size) >= need);
  assign big = (NW+1)'(rd_data.size) >=
               (NW+1)'(need) + (NW+1)'(HEADER_BYTES + ALIGN_BYTES);
  assign split_ok = big && (count < CMAX);

  assign m_ent = '{start: rd_data.start, size: rd_data.size,
                   free: rd_data.free || (idx == hit_idx)};
  assign merge_hit = (idx != '0) && acc.free && m_ent.free;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = widx[IW-1:0];
    wr_data = acc;
    rd_addr = idx[IW-1:0];
    case (state)
      S_SHWR: begin
        wr_en = 1'b1;
        wr_addr = widx[IW-1:0];
        wr_data = rd_data;
      end
      S_SPLIT: begin
        wr_en = 1'b1;
        wr_addr = do_split ? widx[IW-1:0] : hit_idx[IW-1:0];
        wr_data = do_split ? '{start: ins_start, size: ins_size, free: 1'b1} : hit;
      end
      S_MCHK: begin
        wr_en = (idx != '0) && !merge_hit;
        wr_addr = widx[IW-1:0];
        wr_data = acc;
      end
      S_MEND: begin
        wr_en = 1'b1;
        wr_addr = widx[IW-1:0];
        wr_data = acc;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
      out_addr <= res_addr;
      out_status <= res_status;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CW'(1);
      e0_written <= 1'b0;
    end else begin
      if (wr_en && wr_addr == '0) e0_written <= 1'b1;
      case (state)
        S_IDLE: if (s_axis_tvalid) begin
          op <= s_axis_tdata[0];
          need <= need_w;
          addr <= s_axis_tdata[41:22];
          idx <= '0;
          res_addr <= '0;
          if (s_axis_tdata[0] == OP_ALLOC && req_in == '0) begin
            res_status <= ST_ZERO;
            state <= S_OUT;
          end else if (s_axis_tdata[0] == OP_FREE && s_axis_tdata[41:22] == '0) begin
            res_status <= ST_DONE;
            state <= S_OUT;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (op == OP_ALLOC) begin
            if (fits) begin
              hit_idx <= idx;
              hit <= '{start: rd_data.start,
                       size: split_ok ? need[SW-1:0] : rd_data.size, free: 1'b0};
              res_addr <= ADDR_W'(rd_data.start + HDR);
              res_status <= ST_DONE;
              do_split <= split_ok;
              ins_start <= rd_data.start + HDR + need[SW-1:0];
              ins_size <= rd_data.size - need[SW-1:0] - HDR;
              if (split_ok) begin
                count <= count + CW'(1);
                if (count - CW'(1) == idx) begin
                  widx <= idx + CW'(1);
                  state <= S_SPLIT;
                end else begin
                  idx <= count - CW'(1);
                  widx <= count;
                  state <= S_SHRD;
                end
              end else begin
                state <= S_SPLIT;
              end
            end else if (idx + CW'(1) >= count) begin
              res_status <= ST_NO_FIT;
              state <= S_OUT;
            end else begin
              idx <= idx + CW'(1);
              state <= S_RD;
            end
          end else begin
            if (PW'(rd_data.start) + PW'(HDR) == PW'(addr)) begin
              hit_idx <= idx;
              idx <= '0;
              widx <= '0;
              res_status <= ST_DONE;
              state <= S_MRD;
            end else if (idx + CW'(1) >= count) begin
              res_status <= ST_BAD;
              state <= S_OUT;
            end else begin
              idx <= idx + CW'(1);
              state <= S_RD;
            end
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          if (idx - CW'(1) == hit_idx) begin
            widx <= idx;
            state <= S_SPLIT;
          end else begin
            idx <= idx - CW'(1);
            widx <= widx - CW'(1);
            state <= S_SHRD;
          end
        end
        S_SPLIT: begin
          if (do_split) begin
            do_split <= 1'b0;
          end else begin
            state <= S_OUT;
          end
        end
        S_MRD: state <= S_MCHK;
        S_MCHK: begin
          if (merge_hit) begin
            acc <= '{start: acc.start, size: acc.size + HDR + m_ent.size, free: 1'b1};
          end else begin
            acc <= m_ent;
            if (idx != '0) widx <= widx + CW'(1);
          end
          if (idx + CW'(1) >= count) begin
            state <= S_MEND;
          end else begin
            idx <= idx + CW'(1);
            state <= S_MRD;
          end
        end
        S_MEND: begin
          count <= widx + CW'(1);
          state <= S_OUT;
        end
        S_OUT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/ffha_checker.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator port checker
// Watches the stream ports of the allocator over time.
// ----------------------------------------------------------------------------
`default_nettype none
module ffha_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  import ffha_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("reply dropped under stall");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00)
    else $error("reply pad bits set");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[21:20] != ST_DONE |-> m_axis_tdata[19:0] == '0)
    else $error("failed reply carries an address");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready after accept");
endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
